// File: design/rws_pkg.sv
`timescale 1ns / 1ps
package rws_pkg;

   localparam int VALUE_W = 48;
   localparam int FRAC_W  = 28;
   localparam int COUNT_W = 32;
   localparam int DIV_W   = VALUE_W + FRAC_W;
   localparam int VAR_W   = 36;
   localparam int OUT_W   = 32;
   localparam int STEP_W  = 7;

   // Iteration counts of the shared divider and root unit, less one.
   localparam logic [STEP_W-1:0] RET_STEPS  = STEP_W'(DIV_W - 1);
   localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(COUNT_W);
   localparam logic [STEP_W-1:0] WIDE_STEPS = STEP_W'(63);
   localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(OUT_W - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE, S_RET_DIV, S_RET_FIN, S_MEAN_LD, S_MEAN_DIV, S_MEAN_FIN,
      S_MUL_SM, S_ACC_SM, S_MUL_DS, S_ACC_DS, S_VAR_LD, S_VAR_DIV, S_VAR_FIN,
      S_SD_ROOT, S_SD_FIN, S_DD_LD, S_DD_DIV, S_DD_FIN, S_DD_ROOT, S_DDS_FIN,
      S_OUT_EMPTY, S_OUT_STATS
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_START, OP_CAPTURE, OP_RET_LD, OP_DIV_STEP, OP_RET_FIN,
      OP_MEAN_LD, OP_MEAN_FIN, OP_MUL_SM, OP_ACC_SM, OP_MUL_DS, OP_ACC_DS,
      OP_VAR_LD, OP_VAR_FIN, OP_ROOT_STEP, OP_SD_FIN, OP_DD_LD, OP_DD_FIN,
      OP_DDS_FIN, OP_RESULT_EMPTY, OP_RESULT_STATS
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic start;
      logic prev_zero;
      logic count_ge2;
   } status_type;

endpackage

// File: design/rws_ctrl.sv
`timescale 1ns / 1ps
module rws_ctrl
   import rws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.op       = OP_NONE;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.start) begin
               cmd.op   = OP_START;
               state_in = S_OUT_EMPTY;
            end else if (status.prev_zero) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_OUT_EMPTY;
            end else begin
               cmd.op   = OP_RET_LD;
               step_in  = RET_STEPS;
               state_in = S_RET_DIV;
            end
         end
         S_RET_DIV, S_MEAN_DIV, S_VAR_DIV, S_DD_DIV, S_SD_ROOT, S_DD_ROOT: begin
            cmd.op = (state_ff == S_SD_ROOT || state_ff == S_DD_ROOT) ?
                     OP_ROOT_STEP : OP_DIV_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               unique case (state_ff)
                  S_RET_DIV:  state_in = S_RET_FIN;
                  S_MEAN_DIV: state_in = S_MEAN_FIN;
                  S_VAR_DIV:  state_in = S_VAR_FIN;
                  S_DD_DIV:   state_in = S_DD_FIN;
                  S_SD_ROOT:  state_in = S_SD_FIN;
                  default:    state_in = S_DDS_FIN;
               endcase
            end
         end
         S_RET_FIN: begin
            cmd.op   = OP_RET_FIN;
            state_in = S_MEAN_LD;
         end
         S_MEAN_LD: begin
            cmd.op   = OP_MEAN_LD;
            step_in  = MEAN_STEPS;
            state_in = S_MEAN_DIV;
         end
         S_MEAN_FIN: begin
            cmd.op   = OP_MEAN_FIN;
            state_in = S_MUL_SM;
         end
         S_MUL_SM: begin
            cmd.op   = OP_MUL_SM;
            state_in = S_ACC_SM;
         end
         S_ACC_SM: begin
            cmd.op   = OP_ACC_SM;
            state_in = S_MUL_DS;
         end
         S_MUL_DS: begin
            cmd.op   = OP_MUL_DS;
            state_in = S_ACC_DS;
         end
         S_ACC_DS: begin
            cmd.op   = OP_ACC_DS;
            state_in = status.count_ge2 ? S_VAR_LD : S_DD_LD;
         end
         S_VAR_LD: begin
            cmd.op   = OP_VAR_LD;
            step_in  = WIDE_STEPS;
            state_in = S_VAR_DIV;
         end
         S_VAR_FIN: begin
            cmd.op   = OP_VAR_FIN;
            step_in  = ROOT_STEPS;
            state_in = S_SD_ROOT;
         end
         S_SD_FIN: begin
            cmd.op   = OP_SD_FIN;
            state_in = S_DD_LD;
         end
         S_DD_LD: begin
            cmd.op   = OP_DD_LD;
            step_in  = WIDE_STEPS;
            state_in = S_DD_DIV;
         end
         S_DD_FIN: begin
            cmd.op   = OP_DD_FIN;
            step_in  = ROOT_STEPS;
            state_in = S_DD_ROOT;
         end
         S_DDS_FIN: begin
            cmd.op   = OP_DDS_FIN;
            state_in = S_OUT_STATS;
         end
         S_OUT_EMPTY, S_OUT_STATS: begin
            if (out_free) begin
               cmd.op       = (state_ff == S_OUT_STATS) ? OP_RESULT_STATS : OP_RESULT_EMPTY;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> state_ff == S_DECIDE)
      else $error("accepted word not followed by decision");
   a_step_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RET_DIV || state_ff == S_VAR_DIV) && step_ff != '0
      |=> step_ff == $past(step_ff) - 1'b1)
      else $error("iteration counter did not count down");
   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT_STATS || cmd.op == OP_RESULT_EMPTY)
      |-> (!out_valid_ff || out_ready))
      else $error("result written over an untaken word");

endmodule

// File: design/rws_dp.sv
`timescale 1ns / 1ps
module rws_dp
   import rws_pkg::*;
(
   input  logic               clock,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               in_action,
   input  logic [VALUE_W-1:0] in_value,
   output logic [OUT_W-1:0]   out_mean,
   output logic [VAR_W-1:0]   out_variance,
   output logic [OUT_W-1:0]   out_std_dev,
   output logic [OUT_W-1:0]   out_downside,
   output logic               out_mean_valid,
   output logic               out_var_valid,
   output logic               out_saturated,
   output logic [COUNT_W-1:0] out_count,
   input  logic               reset
);

   logic [VALUE_W-1:0]        prev_ff, value_ff;
   logic                      action_ff;
   logic signed [OUT_W-1:0]   mean_ff, ret_ff;
   logic [63:0]               m2_ff, ds_ff, prod_ff;
   logic [COUNT_W-1:0]        cnt_ff;
   logic                      neg_ff, sat_ff, dneg_ff, big_ff, var_valid_ff;
   logic [OUT_W-1:0]          mag_ff, dm_ff, dm2_ff, sd_ff, dd_ff;
   logic [VAR_W-1:0]          var_ff;
   logic [DIV_W-1:0]          dq_ff;
   logic [VALUE_W-1:0]        drem_ff, ddiv_ff;
   logic [63:0]               rad_ff;
   logic [OUT_W-1:0]          root_ff;
   logic [OUT_W+1:0]          srem_ff;

   logic [VALUE_W:0]          rem_sh, rem_sub;
   logic                      fits;
   logic [OUT_W+1:0]          srem_sh, trial;
   logic                      root_fits;
   logic                      neg_now;
   logic [VALUE_W-1:0]        diff;
   logic [OUT_W:0]            lim;
   logic [OUT_W-1:0]          mag_now;
   logic signed [OUT_W:0]     delta, delta2;
   logic signed [OUT_W+1:0]   mean_sum;
   logic [OUT_W-1:0]          mean_new;
   logic [OUT_W:0]            qd;
   logic [64:0]               acc_sum;
   logic [63:0]               acc_base;
   logic                      q_big;

   assign rem_sh    = {drem_ff, dq_ff[DIV_W-1]};
   assign rem_sub   = rem_sh - {1'b0, ddiv_ff};
   assign fits      = rem_sh >= {1'b0, ddiv_ff};
   assign srem_sh   = {srem_ff[OUT_W-1:0], rad_ff[63:62]};
   assign trial     = {root_ff, 2'b01};
   assign root_fits = srem_sh >= trial;

   assign neg_now = value_ff < prev_ff;
   assign diff    = neg_now ? prev_ff - value_ff : value_ff - prev_ff;
   assign lim     = neg_ff ? {1'b0, 1'b1, {(OUT_W-1){1'b0}}} : {2'b00, {(OUT_W-1){1'b1}}};
   assign mag_now = (dq_ff > DIV_W'(lim)) ? lim[OUT_W-1:0] : dq_ff[OUT_W-1:0];

   assign delta    = {ret_ff[OUT_W-1], ret_ff} - {mean_ff[OUT_W-1], mean_ff};
   assign qd       = dq_ff[OUT_W:0];
   assign mean_sum = {{2{mean_ff[OUT_W-1]}}, mean_ff} + (dneg_ff ? -{1'b0, qd} : {1'b0, qd});
   assign mean_new = mean_sum[OUT_W-1:0];
   assign delta2   = {ret_ff[OUT_W-1], ret_ff} - {mean_new[OUT_W-1], mean_new};

   assign acc_base = (cmd.op == OP_ACC_SM) ? m2_ff : ds_ff;
   assign acc_sum  = {1'b0, acc_base} + {29'd0, prod_ff[63:FRAC_W]};
   assign q_big    = |dq_ff[63:VAR_W];

   assign status.start     = action_ff;
   assign status.prev_zero = (prev_ff == '0);
   assign status.count_ge2 = (cnt_ff > COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         mean_ff <= '0;
         m2_ff   <= '0;
         ds_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         case (cmd.op)
            OP_START: begin
               prev_ff <= value_ff;
               mean_ff <= '0;
               m2_ff   <= '0;
               ds_ff   <= '0;
               cnt_ff  <= '0;
            end
            OP_CAPTURE: prev_ff <= value_ff;
            OP_RET_FIN: begin
               prev_ff <= value_ff;
               if (cnt_ff != '1) cnt_ff <= cnt_ff + 1'b1;
            end
            OP_MEAN_FIN: mean_ff <= mean_new;
            OP_ACC_SM: m2_ff <= acc_sum[64] ? '1 : acc_sum[63:0];
            OP_ACC_DS: begin
               if (neg_ff && mag_ff != '0) ds_ff <= acc_sum[64] ? '1 : acc_sum[63:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            action_ff <= in_action;
            value_ff  <= in_value;
         end
         OP_RET_LD: begin
            neg_ff       <= neg_now;
            sat_ff       <= 1'b0;
            var_valid_ff <= 1'b0;
            var_ff       <= '0;
            sd_ff        <= '0;
            dq_ff        <= {diff, {FRAC_W{1'b0}}};
            drem_ff      <= '0;
            ddiv_ff      <= prev_ff;
         end
         OP_DIV_STEP: begin
            drem_ff <= fits ? rem_sub[VALUE_W-1:0] : rem_sh[VALUE_W-1:0];
            dq_ff   <= {dq_ff[DIV_W-2:0], fits};
         end
         OP_RET_FIN: begin
            mag_ff <= mag_now;
            ret_ff <= neg_ff ? -mag_now : mag_now;
            if (dq_ff > DIV_W'(lim) || cnt_ff == '1) sat_ff <= 1'b1;
         end
         OP_MEAN_LD: begin
            dneg_ff <= delta[OUT_W];
            dm_ff   <= delta[OUT_W] ? OUT_W'(-delta) : delta[OUT_W-1:0];
            dq_ff   <= {(delta[OUT_W] ? -delta : delta), {(DIV_W-OUT_W-1){1'b0}}};
            drem_ff <= '0;
            ddiv_ff <= VALUE_W'(cnt_ff);
         end
         OP_MEAN_FIN: dm2_ff <= delta2[OUT_W] ? OUT_W'(-delta2) : delta2[OUT_W-1:0];
         OP_MUL_SM:   prod_ff <= dm_ff * dm2_ff;
         OP_MUL_DS:   prod_ff <= mag_ff * mag_ff;
         OP_ACC_SM, OP_ACC_DS: begin
            if (acc_sum[64] && (cmd.op == OP_ACC_SM || (neg_ff && mag_ff != '0)))
               sat_ff <= 1'b1;
         end
         OP_VAR_LD, OP_DD_LD: begin
            dq_ff   <= {(cmd.op == OP_VAR_LD ? m2_ff : ds_ff), {(DIV_W-64){1'b0}}};
            drem_ff <= '0;
            ddiv_ff <= VALUE_W'(cmd.op == OP_VAR_LD ? cnt_ff - 1'b1 : cnt_ff);
         end
         OP_VAR_FIN, OP_DD_FIN: begin
            // Quotients of 2^36 and above make the root overflow: clamp.
            big_ff  <= q_big;
            rad_ff  <= q_big ? '0 : {dq_ff[VAR_W-1:0], {FRAC_W{1'b0}}};
            root_ff <= '0;
            srem_ff <= '0;
            if (q_big) sat_ff <= 1'b1;
            if (cmd.op == OP_VAR_FIN) begin
               var_valid_ff <= 1'b1;
               var_ff       <= q_big ? '1 : dq_ff[VAR_W-1:0];
            end
         end
         OP_ROOT_STEP: begin
            srem_ff <= root_fits ? srem_sh - trial : srem_sh;
            root_ff <= {root_ff[OUT_W-2:0], root_fits};
            rad_ff  <= {rad_ff[61:0], 2'b00};
         end
         OP_SD_FIN:  sd_ff <= big_ff ? '1 : root_ff;
         OP_DDS_FIN: dd_ff <= big_ff ? '1 : root_ff;
         OP_RESULT_EMPTY: begin
            out_mean       <= '0;
            out_variance   <= '0;
            out_std_dev    <= '0;
            out_downside   <= '0;
            out_mean_valid <= 1'b0;
            out_var_valid  <= 1'b0;
            out_saturated  <= 1'b0;
            out_count      <= cnt_ff;
         end
         OP_RESULT_STATS: begin
            out_mean       <= mean_ff;
            out_variance   <= var_ff;
            out_std_dev    <= sd_ff;
            out_downside   <= dd_ff;
            out_mean_valid <= 1'b1;
            out_var_valid  <= var_valid_ff;
            out_saturated  <= sat_ff;
            out_count      <= cnt_ff;
         end
         default: ;
      endcase
   end

endmodule

// File: design/return_welford_stats_unit.sv
`timescale 1ns / 1ps
// Running return statistics over portfolio values. Each word on req_ gives a
// value and a start flag; each yields exactly one word on rsp_ with the Q28
// mean return, sample variance, standard deviation and downside deviation.
// A start word, or a sample while the stored previous value is zero, gives a
// result word that is zero apart from the count; a counted sample runs the
// whole chain (the first return after a start skips the variance). The work
// is done by the one shared restoring divider (76, 33 and two 64 iterations)
// and the one shared digit-by-digit square root (two 32 iterations). One word
// is worked at a time; the next is taken while a finished result waits to be
// collected.
module return_welford_stats_unit
   import rws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // value[47:0]
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mean_return[31:0], variance[67:32], std_dev[99:68], down_dev[131:100],
   // return_count[163:132], zero fill[167:164]
   output logic [167:0] rsp_tdata,
   // mean_valid[0], variance_valid[1], saturated[2]
   output logic [2:0]   rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   rws_dp u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .in_action      (req_tuser),
      .in_value       (req_tdata),
      .out_mean       (rsp_tdata[31:0]),
      .out_variance   (rsp_tdata[67:32]),
      .out_std_dev    (rsp_tdata[99:68]),
      .out_downside   (rsp_tdata[131:100]),
      .out_mean_valid (rsp_tuser[0]),
      .out_var_valid  (rsp_tuser[1]),
      .out_saturated  (rsp_tuser[2]),
      .out_count      (rsp_tdata[163:132]),
      .reset          (reset)
   );

   assign rsp_tdata[167:164] = 4'd0;

endmodule

// File: tb/sv/return_welford_stats_unit_tb.sv
`timescale 1ns / 1ps
module return_welford_stats_unit_tb;

   typedef struct packed {
      logic [31:0] mean;
      logic [35:0] variance;
      logic [31:0] std_dev;
      logic [31:0] down_dev;
      logic [31:0] count;
      logic        mean_ok;
      logic        var_ok;
      logic        sat;
   } stats_word_type;

   typedef struct {
      logic        action;
      logic [47:0] value;
      logic        fixed;   // result is all zero apart from the count
      logic [31:0] count;
   } stim_row_type;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_START  = 1'b1;
   localparam logic [47:0] VMAX = 48'hFFFF_FFFF_FFFF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   // Own copy of the statistics state.
   logic [47:0]        last_value;
   longint             run_mean;
   longint unsigned    sq_dev_sum;
   longint unsigned    down_sq_sum;
   longint unsigned    n_returns;

   stats_word_type stats_due[$];
   int errors = 0;
   int n_start = 0, n_capture = 0, n_counted = 0, n_sat = 0;
   bit send_idle = 0, recv_stall = 0;

   return_welford_stats_unit i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic longint unsigned root_q28(longint unsigned val, ref bit sat);
      longint unsigned x, r, c;
      if (val >= 64'd1 << 36) begin
         sat = 1;
         return 64'hFFFF_FFFF;
      end
      x = val << 28;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= x) r = c;
      end
      return r;
   endfunction

   function automatic longint unsigned add_clamp(longint unsigned a, longint unsigned b,
                                                 ref bit sat);
      longint unsigned s;
      s = a + b;
      if (s < a) begin
         sat = 1;
         return 64'hFFFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   // Works out the result word of one input word and advances the state.
   function automatic stats_word_type welford_update(logic action, logic [47:0] v);
      stats_word_type w;
      bit sat, neg;
      logic [127:0] quot;
      longint unsigned mag, lim, dm, dm2, q;
      longint ret, delta, delta2;
      w = '0;
      sat = 0;
      if (action == ACT_START) begin
         run_mean = 0; sq_dev_sum = 0; down_sq_sum = 0; n_returns = 0;
         last_value = v;
         return w;
      end
      if (last_value == 0) begin
         last_value = v;
         w.count = n_returns[31:0];
         return w;
      end
      neg = v < last_value;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      quot = {80'd0, (neg ? last_value - v : v - last_value)} << 28;
      quot = quot / {80'd0, last_value};
      if (quot > lim) begin
         mag = lim;
         sat = 1;
      end else begin
         mag = quot[63:0];
      end
      ret = neg ? -longint'(mag) : longint'(mag);
      last_value = v;
      if (n_returns < 64'hFFFF_FFFF) n_returns++;
      else sat = 1;
      delta = ret - run_mean;
      run_mean += delta / longint'(n_returns);
      delta2 = ret - run_mean;
      dm = delta < 0 ? -delta : delta;
      dm2 = delta2 < 0 ? -delta2 : delta2;
      sq_dev_sum = add_clamp(sq_dev_sum, (dm * dm2) >> 28, sat);
      if (neg && mag != 0) down_sq_sum = add_clamp(down_sq_sum, (mag * mag) >> 28, sat);
      if (n_returns >= 2) begin
         q = sq_dev_sum / (n_returns - 1);
         if (q > 64'hF_FFFF_FFFF) begin
            w.variance = '1;
            sat = 1;
         end else begin
            w.variance = q[35:0];
         end
         w.std_dev = root_q28(q, sat);
         w.var_ok = 1;
      end
      w.down_dev = root_q28(down_sq_sum / n_returns, sat);
      w.mean = run_mean[31:0];
      w.mean_ok = 1;
      w.sat = sat;
      w.count = n_returns[31:0];
      return w;
   endfunction

   task automatic send_word(logic action, logic [47:0] v, bit fixed = 0,
                            logic [31:0] cnt = 0);
      stats_word_type w;
      if (send_idle && $urandom_range(0, 99) < 79) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 79);
      end
      w = welford_update(action, v);
      if (fixed) begin
         w = '0;
         w.count = cnt;
      end
      if (action == ACT_START) n_start++;
      else if (!w.mean_ok) n_capture++;
      else n_counted++;
      if (w.sat) n_sat++;
      stats_due.push_back(w);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (stats_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_stall && $urandom_range(0, 99) < 79);
   end

   always @(posedge clock) begin
      stats_word_type exp_w, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mean     = rsp_tdata[31:0];
         got.variance = rsp_tdata[67:32];
         got.std_dev  = rsp_tdata[99:68];
         got.down_dev = rsp_tdata[131:100];
         got.count    = rsp_tdata[163:132];
         got.mean_ok  = rsp_tuser[0];
         got.var_ok   = rsp_tuser[1];
         got.sat      = rsp_tuser[2];
         if (stats_due.size() == 0) begin
            $display("%0t: unexpected result word %h / %h", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_w = stats_due.pop_front();
            if (got !== exp_w) begin
               errors++;
               $display("%0t: mismatch exp mean=%h var=%h sd=%h dd=%h cnt=%0d flags=%b%b%b",
                        $time, exp_w.mean, exp_w.variance, exp_w.std_dev, exp_w.down_dev,
                        exp_w.count, exp_w.mean_ok, exp_w.var_ok, exp_w.sat);
               $display("%0t:          got mean=%h var=%h sd=%h dd=%h cnt=%0d flags=%b%b%b",
                        $time, got.mean, got.variance, got.std_dev, got.down_dev,
                        got.count, got.mean_ok, got.var_ok, got.sat);
            end
         end
      end
   end

   stim_row_type directed[] = '{
      '{ACT_SAMPLE, 48'd1000,       1, 0},  // capture straight after reset
      '{ACT_SAMPLE, 48'd2000,       0, 0},
      '{ACT_SAMPLE, 48'd16000,      0, 0},  // return of exactly seven
      '{ACT_SAMPLE, 48'd144000,     0, 0},  // return clamps
      '{ACT_SAMPLE, 48'd144000,     0, 0},  // zero return
      '{ACT_SAMPLE, 48'd0,          0, 0},  // total loss
      '{ACT_SAMPLE, 48'd5,          1, 5},  // capture after a zero value
      '{ACT_SAMPLE, 48'd4,          0, 0},
      '{ACT_START,  VMAX,           1, 0},
      '{ACT_SAMPLE, 48'd1,          0, 0},  // deepest fall
      '{ACT_SAMPLE, VMAX,           0, 0},  // huge rise
      '{ACT_SAMPLE, VMAX - 1,       0, 0},
      '{ACT_START,  48'd0,          1, 0},
      '{ACT_SAMPLE, 48'd0,          1, 0},  // capture of zero keeps capturing
      '{ACT_SAMPLE, 48'd7,          1, 0},
      '{ACT_SAMPLE, 48'd3,          0, 0},
      '{ACT_SAMPLE, 48'd9,          0, 0},
      '{ACT_SAMPLE, 48'd8,          0, 0},
      '{ACT_START,  48'h8000_0000_0000, 1, 0},
      '{ACT_SAMPLE, 48'h7FFF_FFFF_FFFF, 0, 0}
   };

   initial begin
      logic [47:0] v;
      longint step;
      int pick;
      last_value = 0; run_mean = 0; sq_dev_sum = 0; down_sq_sum = 0; n_returns = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_word(directed[i].action, directed[i].value, directed[i].fixed,
                   directed[i].count);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle  = (phase == 1 || phase == 3);
         recv_stall = (phase == 2 || phase == 3);
         for (int k = 0; k < 235; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               v = {$urandom, $urandom} & VMAX;
               if ($urandom_range(0, 1)) v = v >> $urandom_range(0, 47);
               send_word(ACT_START, v);
            end else if (pick < 13 || last_value == 0) begin
               v = {$urandom, $urandom} & VMAX;
               send_word(ACT_SAMPLE, v >> $urandom_range(0, 47));
            end else if (pick < 15) begin
               send_word(ACT_SAMPLE, 48'd0);
            end else begin
               // A plausible move of up to a fifth of the previous value.
               step = longint'(last_value / 1000) * ($urandom_range(0, 400) - 200)
                      + $urandom_range(0, 20) - 10;
               v = 48'(longint'(last_value) + step);
               send_word(ACT_SAMPLE, v);
            end
            if (k == 120) drain_results();
         end
         drain_results();
      end

      repeat (400) @(posedge clock);
      $display("Covered %0d start, %0d capture and %0d counted words; %0d clamped results.",
               n_start, n_capture, n_counted, n_sat);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
